@@ design/trial_division_factorizer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Trial division factorizer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Implication or plain property, checked on every rising edge outside reset.
`define TDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define TDF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDF_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ design/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared width default, sequencer states and divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

    localparam int NUM_BITS_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUSH
    } tdf_state_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } tdf_div_stat_t;

endpackage

`default_nettype wire

@@ design/tdf_div.sv @@
// ----------------------------------------------------------------------------
// Trial division factorizer bit-serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_factorizer_top_defines.svh"

module tdf_div #(
    parameter int NUM_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [NUM_BITS-1:0]   dividend,
    input  wire logic [NUM_BITS-1:0]   divisor,
    output logic [NUM_BITS-1:0]        quotient,
    output logic [NUM_BITS-1:0]        remainder,
    output tdf_pkg::tdf_div_stat_t     stat
);

    import tdf_pkg::*;

    localparam int CNT_W = $clog2(NUM_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] dsr_reg, dsr_next;

    logic [NUM_BITS:0]   rem_shift;
    logic [NUM_BITS:0]   diff;
    logic                fits;

    // shift next dividend bit into the partial remainder, try the subtract
    assign rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};
    assign fits      = ~diff[NUM_BITS];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            rem_next = fits ? diff[NUM_BITS-1:0] : rem_shift[NUM_BITS-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `TDF_NEVER(a_start_while_busy, clk, rst_n, start && busy_reg, "divider restarted while busy")
    `TDF_ASSERT(a_done_after_busy, clk, rst_n, done_reg |-> $past(busy_reg), "done without a division")
    `TDF_ASSERT(a_rem_bound, clk, rst_n, (busy_reg && dsr_reg != '0) |-> rem_reg < dsr_reg, "partial remainder not below divisor")

endmodule

`default_nettype wire

@@ design/trial_division_factorizer_top.sv @@
// ----------------------------------------------------------------------------
// Trial division factorizer
// Splits an unsigned number into its prime factors, smallest first.
// ----------------------------------------------------------------------------
// One request on the input channel carries a NUM_BITS-bit number; the block
// answers with its prime factors in ascending order, with multiplicity, one
// per output request, and raises last on the final one. Input 1 gives the
// single factor 1; input 0 gives one request with factor 0, last and error
// set. Trial divisors are 2 and then every odd number, tried while the
// divisor does not exceed the quotient (i.e. up to the square root of the
// remaining cofactor); whatever survives is the last prime. Every trial is
// one pass of a bit-serial restoring divider; a found factor then waits
// in the pending register until the output register is free, however long
// the consumer keeps the output register stalled.
// One number is worked on at a time; the next is taken as soon as the last
// factor of the previous one sits in the output register, even while the
// consumer still stalls it. 0 and 1 pass straight to the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_factorizer_top_defines.svh"

module trial_division_factorizer_top #(
    parameter int NUM_BITS = tdf_pkg::NUM_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [NUM_BITS-1:0] number,
    // output channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [NUM_BITS-1:0]      factor,
    output logic                     last,
    output logic                     error
);

    import tdf_pkg::*;

    // sequencer
    tdf_state_t          state_reg, state_next;
    logic                start_reg, start_next;

    // working cofactor and current trial divisor
    logic [NUM_BITS-1:0] n_reg, n_next;
    logic [NUM_BITS-1:0] d_reg, d_next;

    // factor waiting for the output register
    logic [NUM_BITS-1:0] pend_factor_reg, pend_factor_next;
    logic                pend_last_reg, pend_last_next;
    logic                pend_error_reg, pend_error_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [NUM_BITS-1:0] factor_reg, factor_next;
    logic                last_reg, last_next;
    logic                error_reg, error_next;

    logic [NUM_BITS-1:0] quotient;
    logic [NUM_BITS-1:0] remainder;
    tdf_div_stat_t       div_stat;
    logic                out_free;

    tdf_div #(
        .NUM_BITS (NUM_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    // output register can take a new request this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        start_next       = 1'b0;
        n_next           = n_reg;
        d_next           = d_reg;
        pend_factor_next = pend_factor_reg;
        pend_last_next   = pend_last_reg;
        pend_error_next  = pend_error_reg;
        out_valid_next   = out_valid_reg && out_stall;
        factor_next      = factor_reg;
        last_next        = last_reg;
        error_next       = error_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = number;
                    d_next = NUM_BITS'(2);
                    if (number == '0)
                    begin
                        // cannot be factored
                        pend_factor_next = '0;
                        pend_last_next   = 1'b1;
                        pend_error_next  = 1'b1;
                        state_next       = ST_PUSH;
                    end
                    else if (number == NUM_BITS'(1))
                    begin
                        pend_factor_next = NUM_BITS'(1);
                        pend_last_next   = 1'b1;
                        pend_error_next  = 1'b0;
                        state_next       = ST_PUSH;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    pend_error_next = 1'b0;
                    if (d_reg > quotient)
                    begin
                        // past the square root: cofactor is prime
                        pend_factor_next = n_reg;
                        pend_last_next   = 1'b1;
                        state_next       = ST_PUSH;
                    end
                    else if (remainder == '0)
                    begin
                        // divide out and retry the same divisor
                        pend_factor_next = d_reg;
                        pend_last_next   = 1'b0;
                        n_next           = quotient;
                        state_next       = ST_PUSH;
                    end
                    else
                    begin
                        d_next     = (d_reg == NUM_BITS'(2)) ? NUM_BITS'(3)
                                                             : d_reg + NUM_BITS'(2);
                        start_next = 1'b1;
                    end
                end
            end

            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    factor_next    = pend_factor_reg;
                    last_next      = pend_last_reg;
                    error_next     = pend_error_reg;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        d_reg           <= d_next;
        pend_factor_reg <= pend_factor_next;
        pend_last_reg   <= pend_last_next;
        pend_error_reg  <= pend_error_next;
        factor_reg      <= factor_next;
        last_reg        <= last_next;
        error_reg       <= error_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    `TDF_ASSERT(a_done_in_divide, clk, rst_n, div_stat.done |-> state_reg == ST_DIVIDE, "divider finished outside a trial")
    `TDF_ASSERT(a_busy_in_divide, clk, rst_n, div_stat.busy |-> state_reg == ST_DIVIDE, "divider running outside a trial")
    `TDF_ASSERT(a_error_form, clk, rst_n, (out_valid_reg && error_reg) |-> (factor_reg == '0 && last_reg), "error request malformed")
    `TDF_ASSERT(a_mid_factor, clk, rst_n, (out_valid_reg && !last_reg) |-> (factor_reg >= NUM_BITS'(2) && !error_reg), "intermediate factor malformed")

endmodule

`default_nettype wire
